// ===== rtl/utccet_pkg.sv =====
// Shared types, constants and year tables for the UTC to CET/CEST converter.
package utccet_pkg;

  // Offsets from UTC to local time, in seconds
  localparam logic [32:0] SUMMER_OFFSET = 33'd7200;
  localparam logic [32:0] WINTER_OFFSET = 33'd3600;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SWITCH_SECS   = 3600;

  // Years 1970 .. 2107 are covered; 2107 is only needed as an upper year bound
  localparam int unsigned FIRST_YEAR = 1970;
  localparam int unsigned YEAR_COUNT = 138;
  localparam int unsigned YEAR_LAST  = 136;   // last year index an input can reach

  // Zero-based day of year of the 31st of March and October in a common year
  localparam int unsigned DOY_MARCH_31   = 89;
  localparam int unsigned DOY_OCTOBER_31 = 303;

  // seconds / 86400 = (seconds >> 7) / 675, exact for 25-bit operands
  localparam int unsigned DAY_SHIFT = 35;
  localparam logic [25:0] DAY_RECIP =
    26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);

  // Year estimate floor((4 * days + 2) / 1461), exact for 18-bit operands
  localparam int unsigned YEAR_SHIFT = 30;
  localparam logic [19:0] YEAR_RECIP =
    20'(((64'd1 << YEAR_SHIFT) + 64'd1460) / 64'd1461);

  typedef logic [YEAR_COUNT-1:0][15:0] ystart_tab_t;
  typedef logic [YEAR_COUNT-1:0][32:0] switch_tab_t;

  // Item in flight between the year search and the output stage
  typedef struct packed {
    logic        vld;
    logic [31:0] utc;
    logic [7:0]  year_idx;
  } year_stage_t;

  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Day number (since 1970-01-01) of January 1st of each year
  function automatic ystart_tab_t build_ystart();
    ystart_tab_t tab;
    int unsigned acc;
    acc = 0;
    for (int k = 0; k < YEAR_COUNT; k++) begin
      tab[k] = 16'(acc);
      acc = acc + 365 + (is_leap(FIRST_YEAR + k) ? 1 : 0);
    end
    return tab;
  endfunction

  // Instant of the last Sunday of a 31-day month at 01:00 UTC, per year
  function automatic switch_tab_t build_switch(input int unsigned doy31);
    switch_tab_t      tab;
    ystart_tab_t      ys;
    longint unsigned  d31;
    longint unsigned  sun;
    ys = build_ystart();
    for (int k = 0; k < YEAR_COUNT; k++) begin
      d31 = longint'(ys[k]) + doy31 + (is_leap(FIRST_YEAR + k) ? 1 : 0);
      sun = d31 - ((d31 + 4) % 7);  // day 0 was a Thursday
      tab[k] = 33'(sun * SECS_PER_DAY + SWITCH_SECS);
    end
    return tab;
  endfunction

  localparam ystart_tab_t YSTART_TAB = build_ystart();
  localparam switch_tab_t MARCH_TAB  = build_switch(DOY_MARCH_31);
  localparam switch_tab_t OCT_TAB    = build_switch(DOY_OCTOBER_31);

endpackage

// ===== rtl/utccet_year_find.sv =====
// Three-stage pipeline that maps a UTC timestamp to its calendar year index.
module utccet_year_find
  import utccet_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] in_utc,
  output year_stage_t yr
);

  logic        vld1_r, vld2_r, vld3_r;
  logic [31:0] utc1_r, utc2_r, utc3_r;
  logic [50:0] prod1_r, prod1_nxt;
  logic [15:0] days2_r;
  logic [37:0] prod2_r, prod2_nxt;
  logic [17:0] year_num;
  logic [7:0]  year_est;
  logic [7:0]  est_next;
  logic [7:0]  year3_r, year3_nxt;

  // Stage 1: reciprocal multiply for the day number
  assign prod1_nxt = 51'(in_utc[31:7]) * 51'(DAY_RECIP);

  // Stage 2: reciprocal multiply for the year estimate
  assign year_num  = {prod1_r[50:35], 2'b10};
  assign prod2_nxt = 38'(year_num) * 38'(YEAR_RECIP);

  // Stage 3: the estimate is exact or one low (after 2100); fix against year start
  assign year_est = prod2_r[37:30];
  assign est_next = year_est + 8'd1;
  always_comb begin
    if (days2_r >= YSTART_TAB[est_next]) begin
      year3_nxt = est_next;
    end else begin
      year3_nxt = year_est;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      utc1_r  <= in_utc;
      prod1_r <= prod1_nxt;
      utc2_r  <= utc1_r;
      days2_r <= prod1_r[50:35];
      prod2_r <= prod2_nxt;
      utc3_r  <= utc2_r;
      year3_r <= year3_nxt;
    end
  end

  assign yr.vld      = vld3_r;
  assign yr.utc      = utc3_r;
  assign yr.year_idx = year3_r;

endmodule

// ===== rtl/utc_to_central_european_local_time.sv =====
// Top level: UTC seconds to Central European local time with summer flag.
// Accepts one timestamp every cycle while in_stall is low and registers its result
// through day multiply, year multiply, year-start check, switch-table compare and add.
// All stages advance together whenever the output register is empty or being
// taken, so in_stall simply follows out_stall while a result is held. The EU rule
// is applied with precomputed tables of the last Sundays of March and October,
// 01:00 UTC, for 1970..2106; every input in 2106 is standard time. Reset is
// synchronous, active low, and only clears the valid bits.
module utc_to_central_european_local_time
  import utccet_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_utc_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [32:0] out_local_seconds,
  output logic        out_is_summer_time
);

  logic        adv;
  year_stage_t yr;
  logic        out_vld_r;
  logic [32:0] local_r, local_nxt;
  logic        summer_r, summer_nxt;
  logic [32:0] utc_ext;

  // Whole pipeline moves when the output slot frees up
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  utccet_year_find u_year (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_vld (in_valid),
    .in_utc (in_utc_seconds),
    .yr     (yr)
  );

  // Stage 4: compare against the year's switch instants and add the offset
  assign utc_ext = {1'b0, yr.utc};
  always_comb begin
    summer_nxt = (utc_ext >= MARCH_TAB[yr.year_idx]) && (utc_ext < OCT_TAB[yr.year_idx]);
    local_nxt  = utc_ext + (summer_nxt ? SUMMER_OFFSET : WINTER_OFFSET);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= yr.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      local_r  <= local_nxt;
      summer_r <= summer_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_local_seconds  = local_r;
  assign out_is_summer_time = summer_r;

  // Year search never points past the last year an input can reach
  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    yr.vld |-> (yr.year_idx <= 8'(YEAR_LAST)))
    else $error("year index out of range");

  // Summer results lie no earlier than the first switch instant plus two hours
  a_summer_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && summer_r) |-> (local_r >= (MARCH_TAB[0] + SUMMER_OFFSET)))
    else $error("summer time before first switch");

  // Nothing leaves the block in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r)
    else $error("output valid right after reset");

endmodule
